>>> hw/rtl/adsr_segment_planner_macros.svh
// assertion macros for the adsr segment planner
// used by the rtl files that carry concurrent checks; needs i_clk and i_rst_n in scope
`ifndef ADSR_SEGMENT_PLANNER_MACROS_SVH
`define ADSR_SEGMENT_PLANNER_MACROS_SVH
`ifndef SYNTHESIS
`define SP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("adsr segment planner: same-cycle check failed");
`define SP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("adsr segment planner: next-cycle check failed");
`else
`define SP_ASSERT_IMP(lbl, ante, cons)
`define SP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/adsr_sp_pkg.sv
// shared types and constants of the adsr segment planner
// no dependencies
package adsr_sp_pkg;

    localparam int VOL_FRAC  = 16;
    localparam int TIME_FRAC = 16;

    localparam int LEN_W     = 26;
    localparam int OFS_W     = 27;
    localparam int TPROD_W   = 42;
    localparam int DIV_NUM_W = 47;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_Q_W   = 23;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    // floor(2^30 / 127), quotient comes out low by at most one
    localparam logic [23:0] RECIP127 = 24'd8454660;
    localparam int RECIP_SH = 30;
    localparam logic [OFS_W-1:0] LEN_MAX = OFS_W'(33554431);

    typedef enum logic [2:0] {
        CFG_ATTACK_TIME  = 3'd0,
        CFG_DECAY_TIME   = 3'd1,
        CFG_RELEASE_TIME = 3'd2,
        CFG_SUSTAIN      = 3'd3,
        CFG_BASE_VOLUME  = 3'd4,
        CFG_RATE         = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEG_ATTACK,
        SEG_DECAY,
        SEG_SUSTAIN,
        SEG_RELEASE
    } t_seg;

    typedef struct packed {
        logic [6:0]           key;
        logic signed [31:0]   wstart;
        logic [23:0]          wlen;
        logic signed [31:0]   nstart;
        logic [23:0]          nlen;
        logic [LEN_W-1:0]     att;
        logic [LEN_W-1:0]     dec;
        logic [LEN_W-1:0]     rel;
        logic [OFS_W-1:0]     sus_start;
        logic [22:0]          bv;
        logic [15:0]          sus;
        logic [16:0]          q0;
        logic [15:0]          peak;
        logic [DIV_NUM_W-1:0] sprod;
        logic [LEN_W-1:0]     num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_NUM_W-1:0] dnum;
        logic                 neg;
        logic                 is_short;
        logic                 full;
        logic [15:0]          vol;
    } t_note;

endpackage

>>> hw/rtl/adsr_note_if.sv
// note channel of the adsr segment planner
// no dependencies
interface adsr_note_if;
    logic               valid;
    logic               ready;
    logic [6:0]         key;
    logic [6:0]         velocity;
    logic signed [31:0] window_start;
    logic [23:0]        window_length;
    logic signed [31:0] onset_sample;
    logic [23:0]        hold_samples;

    modport source (output valid, key, velocity, window_start, window_length,
                    onset_sample, hold_samples, input ready);
    modport sink (input valid, key, velocity, window_start, window_length,
                  onset_sample, hold_samples, output ready);
endinterface

>>> hw/rtl/adsr_seg_if.sv
// segment channel of the adsr segment planner
// no dependencies
interface adsr_seg_if;
    logic               valid;
    logic               ready;
    logic [6:0]         seg_key;
    logic signed [31:0] seg_window_start;
    logic [23:0]        seg_window_length;
    logic signed [31:0] seg_start;
    logic signed [25:0] seg_length;
    logic [15:0]        vol_from;
    logic [15:0]        vol_to;
    logic               seg_last;

    modport source (output valid, seg_key, seg_window_start, seg_window_length,
                    seg_start, seg_length, vol_from, vol_to, seg_last, input ready);
    modport sink (input valid, seg_key, seg_window_start, seg_window_length,
                  seg_start, seg_length, vol_from, vol_to, seg_last, output ready);
endinterface

>>> hw/rtl/adsr_sp_div.sv
// restoring divider, one quotient bit per cycle
// depends on adsr_sp_pkg; caller guarantees the quotient fits DIV_Q_W bits
module adsr_sp_div
    import adsr_sp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quo
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_Q_W-1:0]   r_acc, n_acc;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_trial;
    logic                 w_ge;

    assign w_trial = {r_rem, r_acc[DIV_Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_Q_W);
            // top bits are already below the divisor
            n_rem  = DIV_DEN_W'(i_num[DIV_NUM_W-1:DIV_Q_W]);
            n_acc  = i_num[DIV_Q_W-1:0];
        end else if (r_busy) begin
            n_rem = w_ge ? DIV_DEN_W'(w_trial - {1'b0, r_den}) : DIV_DEN_W'(w_trial);
            n_acc = {r_acc[DIV_Q_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_acc <= n_acc;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_acc;

endmodule

>>> hw/rtl/adsr_segment_planner.sv
// path: a note passes stages 1 to 4, the division stage, the segment sequencer and
// the output register; a partial attack or partial decay also waits on the serial divider
// throughput: one segment beat per cycle unless o_seg.ready stalls; a full note gives four
// beats, a short one two; divided notes take turns in the one-bit-per-cycle divider
// reset: synchronous, clears all valid bits and loads the register defaults
module adsr_segment_planner
    import adsr_sp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    adsr_note_if.sink   i_note,
    adsr_seg_if.source  o_seg
);

`include "adsr_segment_planner_macros.svh"

    // configuration
    logic [23:0] r_attack, r_decay, r_release;
    logic [15:0] r_sustain, r_base;
    logic [17:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_decay   <= '0;
            r_release <= '0;
            r_sustain <= 16'hFFFF;
            r_base    <= 16'hFFFF;
            r_rate    <= 18'd48000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTACK_TIME:  r_attack  <= i_cfg_data;
                CFG_DECAY_TIME:   r_decay   <= i_cfg_data;
                CFG_RELEASE_TIME: r_release <= i_cfg_data;
                CFG_SUSTAIN:      r_sustain <= i_cfg_data[15:0];
                CFG_BASE_VOLUME:  r_base    <= i_cfg_data[15:0];
                CFG_RATE:         r_rate    <= i_cfg_data[17:0];
                default:          ;
            endcase
        end
    end

    logic  r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_d_v, r_d_wait, r_e_v, r_o_v;
    t_note r_s1, r_s2, r_s3, r_s4, r_d, r_e;
    t_note n_s1, n_s2, n_s3, n_s4, n_d;
    t_seg  r_e_seg, n_seg;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_d_free, w_d_done, w_e_free, w_e_load, w_e_adv, w_out_take;
    logic w_div_start, w_div_busy, w_div_done;
    logic [DIV_Q_W-1:0] w_div_q;

    assign w_out_take = !r_o_v || o_seg.ready;
    assign w_e_adv    = r_e_v && w_out_take;
    assign w_e_free   = !r_e_v || (w_e_adv && (r_e_seg == SEG_RELEASE));
    assign w_d_done   = r_d_v && !r_d_wait;
    assign w_e_load   = w_e_free && w_d_done;
    assign w_d_free   = !r_d_v || w_e_load;
    assign w_rdy4     = !r_s4_v || w_d_free;
    assign w_rdy3     = !r_s3_v || w_rdy4;
    assign w_rdy2     = !r_s2_v || w_rdy3;
    assign w_rdy1     = !r_s1_v || w_rdy2;
    assign i_note.ready = w_rdy1;
    assign w_div_start  = w_d_free && r_s4_v && (r_s4.is_short || !r_s4.full);

    // stage 1: times to sample counts, velocity and sustain products
    logic [TPROD_W-1:0] w_att_p, w_dec_p, w_rel_p;
    logic [31:0]        w_sus_p;

    assign w_att_p = TPROD_W'(r_attack) * TPROD_W'(r_rate);
    assign w_dec_p = TPROD_W'(r_decay) * TPROD_W'(r_rate);
    assign w_rel_p = TPROD_W'(r_release) * TPROD_W'(r_rate);
    assign w_sus_p = 32'(r_sustain) * 32'(r_base);

    always_comb begin
        n_s1        = r_s1;
        n_s1.key    = i_note.key;
        n_s1.wstart = i_note.window_start;
        n_s1.wlen   = i_note.window_length;
        n_s1.nstart = i_note.onset_sample;
        n_s1.nlen   = i_note.hold_samples;
        n_s1.att    = w_att_p[TIME_FRAC +: LEN_W];
        n_s1.dec    = w_dec_p[TIME_FRAC +: LEN_W];
        n_s1.rel    = w_rel_p[TIME_FRAC +: LEN_W];
        n_s1.bv     = 23'(r_base) * 23'(i_note.velocity);
        n_s1.sus    = w_sus_p[VOL_FRAC +: 16];
    end

    // stage 2: reciprocal estimate of peak, segment boundaries, attack numerator
    logic [DIV_NUM_W-1:0] w_q0_p;

    assign w_q0_p = DIV_NUM_W'(r_s1.bv) * DIV_NUM_W'(RECIP127);

    always_comb begin
        n_s2           = r_s1;
        n_s2.q0        = w_q0_p[RECIP_SH +: 17];
        n_s2.sus_start = OFS_W'(r_s1.att) + OFS_W'(r_s1.dec);
        n_s2.is_short  = LEN_W'(r_s1.nlen) < r_s1.att;
        n_s2.full      = OFS_W'(r_s1.nlen) >= n_s2.sus_start;
        n_s2.sprod     = DIV_NUM_W'(r_s1.bv) * DIV_NUM_W'(r_s1.nlen);
    end

    // stage 3: peak correction, decay progress and divisor
    logic [23:0] w_rem127;

    assign w_rem127 = 24'(r_s2.bv) - (24'(r_s2.q0) << 7) + 24'(r_s2.q0);

    always_comb begin
        n_s3      = r_s2;
        n_s3.peak = r_s2.q0[15:0] + 16'(w_rem127 >= 24'd127);
        n_s3.num  = LEN_W'(r_s2.nlen) - r_s2.att;
        n_s3.den  = r_s2.is_short ? (DIV_DEN_W'(r_s2.att) << 7) - DIV_DEN_W'(r_s2.att)
                                  : DIV_DEN_W'(r_s2.dec);
    end

    // stage 4: decay numerator as sign and magnitude, or the attack numerator of a short note
    logic [16:0]          w_diff;
    logic [15:0]          w_mag;
    logic [DIV_NUM_W-1:0] w_dprod;

    assign w_diff  = {1'b0, r_s3.sus} - {1'b0, r_s3.peak};
    assign w_mag   = w_diff[16] ? 16'(-w_diff) : w_diff[15:0];
    assign w_dprod = DIV_NUM_W'(w_mag) * DIV_NUM_W'(r_s3.num);

    always_comb begin
        n_s4      = r_s3;
        n_s4.neg  = w_diff[16];
        n_s4.dnum = r_s3.is_short ? r_s3.sprod : w_dprod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            // zero-length notes are dropped on entry
            if (w_rdy1) r_s1_v <= i_note.valid && (i_note.hold_samples != 24'd0);
            if (w_rdy2) r_s2_v <= r_s1_v;
            if (w_rdy3) r_s3_v <= r_s2_v;
            if (w_rdy4) r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_s1 <= n_s1;
        if (w_rdy2) r_s2 <= n_s2;
        if (w_rdy3) r_s3 <= n_s3;
        if (w_rdy4) r_s4 <= n_s4;
    end

    // division stage
    adsr_sp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_s4.dnum),
        .i_den   (r_s4.den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_q)
    );

    always_comb begin
        n_d = r_d;
        if (w_d_free) begin
            n_d     = r_s4;
            n_d.vol = r_s4.sus;
        end else if (w_div_done) begin
            if (r_d.is_short) begin
                n_d.vol = w_div_q[15:0];
            end else if (r_d.neg) begin
                n_d.vol = r_d.peak - w_div_q[15:0];
            end else begin
                n_d.vol = r_d.peak + w_div_q[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v    <= 1'b0;
            r_d_wait <= 1'b0;
        end else if (w_d_free) begin
            r_d_v    <= r_s4_v;
            r_d_wait <= w_div_start;
        end else if (w_div_done) begin
            r_d_wait <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    // segment sequencer
    always_comb begin
        case (r_e_seg)
            SEG_ATTACK:  n_seg = r_e.is_short ? SEG_RELEASE : SEG_DECAY;
            SEG_DECAY:   n_seg = r_e.full ? SEG_SUSTAIN : SEG_RELEASE;
            SEG_SUSTAIN: n_seg = SEG_RELEASE;
            default:     n_seg = SEG_RELEASE;
        endcase
    end

    logic [OFS_W-1:0] w_ofs, w_len, w_len_sat;
    logic [15:0]      w_vfrom, w_vto;
    logic             w_last;

    always_comb begin
        case (r_e_seg)
            SEG_ATTACK: begin
                w_ofs   = '0;
                w_len   = r_e.is_short ? OFS_W'(r_e.nlen) : OFS_W'(r_e.att);
                w_vfrom = '0;
                w_vto   = r_e.is_short ? r_e.vol : r_e.peak;
                w_last  = 1'b0;
            end
            SEG_DECAY: begin
                w_ofs   = OFS_W'(r_e.att);
                w_len   = r_e.full ? OFS_W'(r_e.dec) : OFS_W'(r_e.num);
                w_vfrom = r_e.peak;
                w_vto   = r_e.vol;
                w_last  = 1'b0;
            end
            SEG_SUSTAIN: begin
                w_ofs   = r_e.sus_start;
                w_len   = OFS_W'(r_e.nlen) - r_e.sus_start;
                w_vfrom = r_e.vol;
                w_vto   = r_e.vol;
                w_last  = 1'b0;
            end
            default: begin
                w_ofs   = OFS_W'(r_e.nlen);
                w_len   = OFS_W'(r_e.rel);
                w_vfrom = r_e.vol;
                w_vto   = '0;
                w_last  = 1'b1;
            end
        endcase
    end

    assign w_len_sat = (w_len > LEN_MAX) ? LEN_MAX : w_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v   <= 1'b0;
            r_e_seg <= SEG_ATTACK;
        end else if (w_e_load) begin
            r_e_v   <= 1'b1;
            r_e_seg <= SEG_ATTACK;
        end else if (w_e_adv) begin
            if (r_e_seg == SEG_RELEASE) begin
                r_e_v <= 1'b0;
            end else begin
                r_e_seg <= n_seg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_load) r_e <= r_d;
    end

    // output register
    logic [6:0]         r_o_key;
    logic signed [31:0] r_o_wstart, r_o_start;
    logic [23:0]        r_o_wlen;
    logic signed [25:0] r_o_len;
    logic [15:0]        r_o_vfrom, r_o_vto;
    logic               r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_out_take) begin
            r_o_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take) begin
            r_o_key    <= r_e.key;
            r_o_wstart <= r_e.wstart;
            r_o_wlen   <= r_e.wlen;
            r_o_start  <= r_e.nstart + $signed(32'(w_ofs));
            r_o_len    <= $signed(w_len_sat[LEN_W-1:0]);
            r_o_vfrom  <= w_vfrom;
            r_o_vto    <= w_vto;
            r_o_last   <= w_last;
        end
    end

    assign o_seg.valid             = r_o_v;
    assign o_seg.seg_key           = r_o_key;
    assign o_seg.seg_window_start  = r_o_wstart;
    assign o_seg.seg_window_length = r_o_wlen;
    assign o_seg.seg_start         = r_o_start;
    assign o_seg.seg_length        = r_o_len;
    assign o_seg.vol_from          = r_o_vfrom;
    assign o_seg.vol_to            = r_o_vto;
    assign o_seg.seg_last          = r_o_last;

    `SP_ASSERT_IMP(a_wait_has_item, r_d_wait, r_d_v)
    `SP_ASSERT_IMP(a_div_start_idle, w_div_start, !w_div_busy)
    `SP_ASSERT_IMP(a_sustain_only_full, r_e_v && (r_e_seg == SEG_SUSTAIN), r_e.full)
    `SP_ASSERT_NXT(a_done_ends_wait, w_div_done, !r_d_wait)

endmodule

>>> tb/adsr_segment_checker.sv
`timescale 1ns / 100ps
// segment checker for the adsr segment planner: tracks register writes, plans the
// expected segments of every accepted note and compares each segment beat
// depends on adsr_sp_pkg, adsr_note_if and adsr_seg_if
module adsr_segment_checker
    import adsr_sp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    adsr_note_if        i_note,
    adsr_seg_if         i_seg,
    output int          o_failures,
    output int          o_pending,
    output int          o_checked
);

    localparam longint SEG_LEN_MAX = 33554431;

    typedef struct {
        logic [6:0]         key;
        logic signed [31:0] wstart;
        logic [23:0]        wlen;
        logic signed [31:0] start;
        logic signed [25:0] len;
        logic [15:0]        vfrom;
        logic [15:0]        vto;
        logic               last;
    } t_plan_seg;

    t_plan_seg planned_segs[$];

    logic [23:0] attack_t, decay_t, release_t;
    logic [15:0] sustain_lvl, base_vol;
    logic [17:0] smp_rate;

    // note fields latched while its segments are planned
    logic [6:0]         n_key;
    logic signed [31:0] n_wstart;
    logic [23:0]        n_wlen;
    logic signed [31:0] n_start;

    initial begin
        o_failures = 0;
        o_checked  = 0;
    end

    assign o_pending = planned_segs.size();

    function automatic longint samples_of(logic [23:0] t);
        return longint'((64'(t) * 64'(smp_rate)) >> TIME_FRAC);
    endfunction

    function automatic void add_seg(longint offset, longint length, longint vf, longint vt,
                                    logic last);
        t_plan_seg s;
        if (length > SEG_LEN_MAX) length = SEG_LEN_MAX;
        if (length < 0) length = 0;
        s.key    = n_key;
        s.wstart = n_wstart;
        s.wlen   = n_wlen;
        s.start  = n_start + 32'(offset);
        s.len    = 26'(length);
        s.vfrom  = 16'(vf);
        s.vto    = 16'(vt);
        s.last   = last;
        planned_segs.push_back(s);
    endfunction

    function automatic void plan_envelope(logic [6:0] vel_in, logic [23:0] nlen_in);
        longint vel, nlen, base, att, dec, rel, sus_at, peak, sus_vol, vol, num;
        vel  = vel_in;
        nlen = nlen_in;
        base = base_vol;
        if (nlen == 0) return;
        att     = samples_of(attack_t);
        dec     = samples_of(decay_t);
        rel     = samples_of(release_t);
        sus_at  = att + dec;
        peak    = (base * vel) / 127;
        sus_vol = (longint'(sustain_lvl) * base) >>> VOL_FRAC;
        if (nlen < att) begin
            // note released during attack, ramp stops part way up
            vol = (base * vel * nlen) / (127 * att);
            add_seg(0, nlen, 0, vol, 1'b0);
        end else begin
            add_seg(0, att, 0, peak, 1'b0);
            if (nlen >= sus_at) begin
                add_seg(att, dec, peak, sus_vol, 1'b0);
                vol = sus_vol;
                add_seg(sus_at, nlen - sus_at, vol, vol, 1'b0);
            end else begin
                // released inside decay, interpolate with truncation toward zero
                num = nlen - att;
                vol = peak + ((sus_vol - peak) * num) / dec;
                add_seg(att, num, peak, vol, 1'b0);
            end
        end
        add_seg(nlen, rel, vol, 0, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_plan_seg e;
        if (!i_rst_n) begin
            attack_t    = '0;
            decay_t     = '0;
            release_t   = '0;
            sustain_lvl = 16'hFFFF;
            base_vol    = 16'hFFFF;
            smp_rate    = 18'd48000;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ATTACK_TIME:  attack_t    = i_cfg_data;
                    CFG_DECAY_TIME:   decay_t     = i_cfg_data;
                    CFG_RELEASE_TIME: release_t   = i_cfg_data;
                    CFG_SUSTAIN:      sustain_lvl = i_cfg_data[15:0];
                    CFG_BASE_VOLUME:  base_vol    = i_cfg_data[15:0];
                    CFG_RATE:         smp_rate    = i_cfg_data[17:0];
                    default: ;
                endcase
            end
            if (i_note.valid && i_note.ready) begin
                n_key    = i_note.key;
                n_wstart = i_note.window_start;
                n_wlen   = i_note.window_length;
                n_start  = i_note.onset_sample;
                plan_envelope(i_note.velocity, i_note.hold_samples);
            end
            if (i_seg.valid && i_seg.ready) begin
                o_checked++;
                if (planned_segs.size() == 0) begin
                    $error("segment beat with nothing expected");
                    o_failures++;
                end else begin
                    e = planned_segs.pop_front();
                    if (i_seg.seg_key !== e.key) begin
                        $error("seg_key exp %0d got %0d", e.key, i_seg.seg_key);
                        o_failures++;
                    end
                    if (i_seg.seg_window_start !== e.wstart) begin
                        $error("seg_window_start exp %0d got %0d", e.wstart,
                               i_seg.seg_window_start);
                        o_failures++;
                    end
                    if (i_seg.seg_window_length !== e.wlen) begin
                        $error("seg_window_length exp %0d got %0d", e.wlen,
                               i_seg.seg_window_length);
                        o_failures++;
                    end
                    if (i_seg.seg_start !== e.start) begin
                        $error("seg_start exp %0d got %0d", e.start, i_seg.seg_start);
                        o_failures++;
                    end
                    if (i_seg.seg_length !== e.len) begin
                        $error("seg_length exp %0d got %0d", e.len, i_seg.seg_length);
                        o_failures++;
                    end
                    if (i_seg.vol_from !== e.vfrom) begin
                        $error("vol_from exp %0d got %0d", e.vfrom, i_seg.vol_from);
                        o_failures++;
                    end
                    if (i_seg.vol_to !== e.vto) begin
                        $error("vol_to exp %0d got %0d", e.vto, i_seg.vol_to);
                        o_failures++;
                    end
                    if (i_seg.seg_last !== e.last) begin
                        $error("seg_last exp %0b got %0b", e.last, i_seg.seg_last);
                        o_failures++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_adsr_segment_planner.sv
`timescale 1ns / 100ps
// top of the adsr segment planner testbench: clock, reset, register phases, note stimulus
// depends on adsr_sp_pkg, the two channel interfaces, the planner and adsr_segment_checker
module tb_adsr_segment_planner;
    import adsr_sp_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [23:0] cfg_data;
    int          failures, pending, checked;
    int          send_idle_pct, recv_stall_pct;
    int          notes_sent;
    longint      att_len, dec_len;
    logic [23:0] cur_att, cur_dec;
    logic [17:0] cur_rate;

    adsr_note_if note_ch();
    adsr_seg_if  seg_ch();

    adsr_segment_planner dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_note     (note_ch),
        .o_seg      (seg_ch)
    );

    adsr_segment_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_note     (note_ch),
        .i_seg      (seg_ch),
        .o_failures (failures),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(negedge i_clk) begin
        seg_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        if (idx == CFG_ATTACK_TIME) cur_att = value;
        if (idx == CFG_DECAY_TIME) cur_dec = value;
        if (idx == CFG_RATE) cur_rate = value[17:0];
        @(negedge i_clk);
        cfg_we = 1'b0;
        att_len = longint'((64'(cur_att) * 64'(cur_rate)) >> TIME_FRAC);
        dec_len = longint'((64'(cur_dec) * 64'(cur_rate)) >> TIME_FRAC);
    endtask

    task automatic set_regs(logic [23:0] a, logic [23:0] d, logic [23:0] r, logic [23:0] s,
                            logic [23:0] b, logic [23:0] rate);
        write_reg(CFG_ATTACK_TIME, a);
        write_reg(CFG_DECAY_TIME, d);
        write_reg(CFG_RELEASE_TIME, r);
        write_reg(CFG_SUSTAIN, s);
        write_reg(CFG_BASE_VOLUME, b);
        write_reg(CFG_RATE, rate);
    endtask

    // wait for every planned segment, then let the pipeline run idle before the next phase
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic send_note(logic [6:0] key, logic [6:0] vel, logic [31:0] ws,
                             logic [23:0] wl, logic [31:0] ns, logic [23:0] nl);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            note_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        note_ch.valid         = 1'b1;
        note_ch.key           = key;
        note_ch.velocity      = vel;
        note_ch.window_start  = ws;
        note_ch.window_length = wl;
        note_ch.onset_sample  = ns;
        note_ch.hold_samples  = nl;
        @(posedge i_clk);
        while (!note_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        note_ch.valid = 1'b0;
        notes_sent++;
    endtask

    // note lengths cluster around the attack and decay boundaries
    task automatic send_random(int count, int pause_at);
        int     pick;
        longint nl;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) while (pending != 0) @(negedge i_clk);
            pick = $urandom_range(99);
            if (pick < 8) nl = 0;
            else if (pick < 35) nl = $urandom_range(0, 32'(att_len));
            else if (pick < 65) nl = att_len + $urandom_range(0, 32'(dec_len));
            else if (pick < 88) nl = att_len + dec_len + $urandom_range(0, 1000);
            else nl = $urandom_range(0, 24'hFFFFFF);
            if (nl > 24'hFFFFFF) nl = 24'hFFFFFF;
            send_note(7'($urandom), 7'($urandom), $urandom, 24'($urandom), $urandom,
                      24'(nl));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        note_ch.valid  = 1'b0;
        note_ch.key    = '0;
        note_ch.velocity      = '0;
        note_ch.window_start  = '0;
        note_ch.window_length = '0;
        note_ch.onset_sample  = '0;
        note_ch.hold_samples  = '0;
        seg_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        notes_sent     = 0;
        cur_att        = '0;
        cur_dec        = '0;
        cur_rate       = 18'd48000;
        att_len        = 0;
        dec_len        = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // register defaults: zero attack, decay and release times
        send_note(7'd0, 7'd0, 32'h8000_0000, 24'd0, 32'sd0, 24'd0);
        send_note(7'd127, 7'd127, 32'h7FFF_FFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 24'd1);
        send_note(7'd64, 7'd127, 32'd0, 24'd100, 32'hFFFF_FFFF, 24'hFFFFFF);
        drain();

        set_regs(24'h000400, 24'h000600, 24'h000300, 24'h008000, 24'h00C000, 24'd48000);
        send_note(7'd1, 7'd127, 32'd5, 24'd10, 32'd100, 24'd1);
        send_note(7'd2, 7'd0, 32'd5, 24'd10, 32'd100, 24'(att_len - 1));
        send_note(7'd3, 7'd127, 32'd5, 24'd10, 32'd100, 24'(att_len));
        send_note(7'd4, 7'd100, 32'd5, 24'd10, 32'd100, 24'(att_len + dec_len / 2));
        send_note(7'd5, 7'd127, 32'd5, 24'd10, 32'd100, 24'(att_len + dec_len - 1));
        send_note(7'd6, 7'd127, 32'd5, 24'd10, 32'd100, 24'(att_len + dec_len));
        send_note(7'd7, 7'd1, 32'd5, 24'd10, 32'h7FFF_FF00, 24'd50000);
        send_note(7'd8, 7'd127, 32'd5, 24'd10, 32'd0, 24'd0);
        drain();

        send_idle_pct = 48;
        send_random(32, 16);
        drain();

        // longest times at the highest rate overflow the segment length field
        set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd192000);
        write_reg(CFG_UNUSED, 24'h000001);
        send_idle_pct  = 0;
        recv_stall_pct = 48;
        send_note(7'd9, 7'd127, 32'd0, 24'd0, 32'd0, 24'hFFFFFF);
        send_note(7'd10, 7'd127, 32'd0, 24'd0, 32'd0, 24'd3);
        send_random(30, -1);
        drain();

        // zero rate makes every time-derived length zero
        set_regs(24'h123456, 24'h00FFFF, 24'h0ABCDE, 24'd0, 24'd0, 24'd0);
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        send_random(24, -1);
        drain();

        set_regs(24'($urandom_range(0, 24'h2000)), 24'($urandom_range(0, 24'h2000)),
                 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom_range(1, 192000)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(36, -1);
        drain();

        set_regs(24'($urandom), 24'($urandom_range(1, 24'h800)),
                 24'($urandom_range(0, 24'h400)), 24'($urandom), 24'($urandom),
                 24'($urandom_range(1, 500)));
        send_idle_pct = 48;
        send_random(32, -1);
        drain();

        $display("notes sent: %0d, segment beats checked: %0d, across six register settings",
                 notes_sent, checked);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
